// ----- src/rgbhsv_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: shared types and constants
// Pixel and result structs, the codes for the winning channel and the fixed
// constants of the hue arithmetic.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [8:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } rsp_type;

   // Channel that holds the maximum; red wins ties over green, green over blue.
   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;

   typedef struct packed {
      logic [1:0] sel;    // channel holding the maximum
      logic       neg;    // hue difference is negative
      logic       gray;   // delta is zero
      logic       black;  // maximum is zero
   } ctrl_type;

   // The hue quotient never exceeds 60, so six quotient bits suffice.
   localparam int HUE_QBITS = 6;
   localparam int HUE_SCALE = 60;

   localparam logic [8:0] HUE_GREEN = 9'd120;
   localparam logic [8:0] HUE_BLUE  = 9'd240;
   localparam logic [8:0] HUE_FULL  = 9'd360;

endpackage

// ----- src/rgbhsv_front.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV front stage
// Finds the largest and smallest channel, the winning channel, delta and the
// signed channel difference that sets the hue, and registers them.
// ----------------------------------------------------------------------------
module rgbhsv_front
   import rgbhsv_pkg::*;
#(
   parameter int CB = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  req_type       in_pixel,
   output logic          out_valid,
   output ctrl_type      out_ctrl,
   output logic [CB-1:0] out_mx,
   output logic [CB-1:0] out_delta,
   output logic [CB-1:0] out_mag
);

   logic [CB-1:0] r;
   logic [CB-1:0] g;
   logic [CB-1:0] b;
   logic [CB-1:0] mx;
   logic [CB-1:0] mn;
   logic [1:0]    sel;
   logic [CB:0]   sdiff;
   logic [CB:0]   amag;

   logic          valid_ff;
   logic          valid_in;
   ctrl_type      ctrl_ff;
   ctrl_type      ctrl_in;
   logic [CB-1:0] mx_ff;
   logic [CB-1:0] delta_ff;
   logic [CB-1:0] delta_in;
   logic [CB-1:0] mag_ff;
   logic [CB-1:0] mag_in;

   // Bits above the channel width are dropped here.
   assign r = CB'(in_pixel.red);
   assign g = CB'(in_pixel.green);
   assign b = CB'(in_pixel.blue);

   always_comb begin
      if (r >= g && r >= b) begin
         sel   = SEL_RED;
         mx    = r;
         sdiff = {1'b0, g} - {1'b0, b};
      end else if (g >= b) begin
         sel   = SEL_GREEN;
         mx    = g;
         sdiff = {1'b0, b} - {1'b0, r};
      end else begin
         sel   = SEL_BLUE;
         mx    = b;
         sdiff = {1'b0, r} - {1'b0, g};
      end
      if (r <= g && r <= b) begin
         mn = r;
      end else if (g <= b) begin
         mn = g;
      end else begin
         mn = b;
      end
      amag     = sdiff[CB] ? (~sdiff + 1'b1) : sdiff;
      mag_in   = amag[CB-1:0];
      delta_in = mx - mn;
      valid_in = in_valid;
      ctrl_in.sel   = sel;
      ctrl_in.neg   = sdiff[CB];
      ctrl_in.gray  = (delta_in == '0);
      ctrl_in.black = (mx == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff  <= ctrl_in;
      mx_ff    <= mx;
      delta_ff <= delta_in;
      mag_ff   <= mag_in;
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_mx    = mx_ff;
   assign out_delta = delta_ff;
   assign out_mag   = mag_ff;

endmodule

// ----- src/rgbhsv_cell.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV divider cell
// One restoring division step for both the saturation and the hue quotient,
// registered, with the side information carried alongside.
// ----------------------------------------------------------------------------
module rgbhsv_cell
   import rgbhsv_pkg::*;
#(
   parameter int CB    = 8,
   parameter int NSTEP = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ctrl_type         in_ctrl,
   input  logic [CB-1:0]    in_mx,
   input  logic [CB-1:0]    in_delta,
   input  logic [CB-1:0]    in_sat_rem,
   input  logic [NSTEP-1:0] in_sat_num,
   input  logic [NSTEP-1:0] in_sat_quo,
   input  logic [CB-1:0]    in_hue_rem,
   input  logic [NSTEP-1:0] in_hue_num,
   input  logic [NSTEP-1:0] in_hue_quo,
   output logic             out_valid,
   output ctrl_type         out_ctrl,
   output logic [CB-1:0]    out_mx,
   output logic [CB-1:0]    out_delta,
   output logic [CB-1:0]    out_sat_rem,
   output logic [NSTEP-1:0] out_sat_num,
   output logic [NSTEP-1:0] out_sat_quo,
   output logic [CB-1:0]    out_hue_rem,
   output logic [NSTEP-1:0] out_hue_num,
   output logic [NSTEP-1:0] out_hue_quo
);

   logic [CB:0]      sat_trial;
   logic [CB:0]      hue_trial;
   logic [CB:0]      sat_diff;
   logic [CB:0]      hue_diff;
   logic             sat_bit;
   logic             hue_bit;

   logic             valid_ff;
   ctrl_type         ctrl_ff;
   logic [CB-1:0]    mx_ff;
   logic [CB-1:0]    delta_ff;
   logic [CB-1:0]    sat_rem_ff;
   logic [CB-1:0]    sat_rem_in;
   logic [NSTEP-1:0] sat_num_ff;
   logic [NSTEP-1:0] sat_quo_ff;
   logic [CB-1:0]    hue_rem_ff;
   logic [CB-1:0]    hue_rem_in;
   logic [NSTEP-1:0] hue_num_ff;
   logic [NSTEP-1:0] hue_quo_ff;

   // The partial remainder stays below the divisor, so after a successful
   // subtraction it fits the channel width again.
   always_comb begin
      sat_trial  = {in_sat_rem, in_sat_num[NSTEP-1]};
      hue_trial  = {in_hue_rem, in_hue_num[NSTEP-1]};
      sat_diff   = sat_trial - {1'b0, in_mx};
      hue_diff   = hue_trial - {1'b0, in_delta};
      sat_bit    = (sat_trial >= {1'b0, in_mx});
      hue_bit    = (hue_trial >= {1'b0, in_delta});
      sat_rem_in = sat_bit ? sat_diff[CB-1:0] : sat_trial[CB-1:0];
      hue_rem_in = hue_bit ? hue_diff[CB-1:0] : hue_trial[CB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff    <= in_ctrl;
      mx_ff      <= in_mx;
      delta_ff   <= in_delta;
      sat_rem_ff <= sat_rem_in;
      sat_num_ff <= in_sat_num << 1;
      sat_quo_ff <= {in_sat_quo[NSTEP-2:0], sat_bit};
      hue_rem_ff <= hue_rem_in;
      hue_num_ff <= in_hue_num << 1;
      hue_quo_ff <= {in_hue_quo[NSTEP-2:0], hue_bit};
   end

   assign out_valid   = valid_ff;
   assign out_ctrl    = ctrl_ff;
   assign out_mx      = mx_ff;
   assign out_delta   = delta_ff;
   assign out_sat_rem = sat_rem_ff;
   assign out_sat_num = sat_num_ff;
   assign out_sat_quo = sat_quo_ff;
   assign out_hue_rem = hue_rem_ff;
   assign out_hue_num = hue_num_ff;
   assign out_hue_quo = hue_quo_ff;

endmodule

// ----- src/rgbhsv_back.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV output stage
// Floors the hue for negative differences, adds the sector offset, forces the
// gray and black cases and registers the result with its strobe.
// ----------------------------------------------------------------------------
module rgbhsv_back
   import rgbhsv_pkg::*;
#(
   parameter int CB    = 8,
   parameter int NSTEP = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ctrl_type         in_ctrl,
   input  logic [CB-1:0]    in_mx,
   input  logic [NSTEP-1:0] in_sat_quo,
   input  logic [NSTEP-1:0] in_hue_quo,
   input  logic [CB-1:0]    in_hue_rem,
   output logic             out_strobe,
   output rsp_type          out_data
);

   logic [8:0] q;
   logic [8:0] qc;

   logic       strobe_ff;
   rsp_type    data_ff;
   rsp_type    data_in;

   always_comb begin
      q  = 9'(in_hue_quo);
      // A negative quotient floors away from zero when there is a remainder.
      qc = q + {8'd0, (in_hue_rem != '0)};
      data_in.brightness = 8'(in_mx);
      data_in.saturation = in_ctrl.black ? 8'd0 : 8'(in_sat_quo);
      case (in_ctrl.sel)
         SEL_RED: begin
            data_in.hue = in_ctrl.neg ? (HUE_FULL - qc) : q;
         end
         SEL_GREEN: begin
            data_in.hue = in_ctrl.neg ? (HUE_GREEN - qc) : (HUE_GREEN + q);
         end
         SEL_BLUE: begin
            data_in.hue = in_ctrl.neg ? (HUE_BLUE - qc) : (HUE_BLUE + q);
         end
         default: begin
            data_in.hue = '0;
         end
      endcase
      if (in_ctrl.gray) begin
         data_in.hue = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_strobe = strobe_ff;
   assign out_data   = data_ff;

endmodule

// ----- src/rgb_to_hsv_pixel_top.sv -----
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter
// Converts one 8-bit RGB pixel per clock into hue (degrees), saturation and
// brightness through a front stage, a row of divider cells and an output stage.
//
//   Channel   Ports                      Direction  Transfer when
//   request   start, busy, req_data      in         start high and busy low
//   response  rsp_strobe, rsp_data       out        rsp_strobe high
//
// From transfer to result a pixel passes through one front stage, one divider
// cell per quotient bit and one output stage.
// A new pixel may be transferred in every cycle; busy is always low.
// Synchronous reset clears all valid flags; nothing in flight survives it.
// The receiver cannot stall, so every result appears for exactly one cycle.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_top
   import rgbhsv_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CB    = CHANNEL_BITS;
   localparam int NSTEP = (CB > HUE_QBITS) ? CB : HUE_QBITS;
   localparam int NW    = CB + NSTEP;

   logic             accept;

   logic             f_valid;
   ctrl_type         f_ctrl;
   logic [CB-1:0]    f_mx;
   logic [CB-1:0]    f_delta;
   logic [CB-1:0]    f_mag;
   logic [NW-1:0]    sat_n;
   logic [NW-1:0]    hue_n;

   logic             c_valid   [0:NSTEP];
   ctrl_type         c_ctrl    [0:NSTEP];
   logic [CB-1:0]    c_mx      [0:NSTEP];
   logic [CB-1:0]    c_delta   [0:NSTEP];
   logic [CB-1:0]    c_sat_rem [0:NSTEP];
   logic [NSTEP-1:0] c_sat_num [0:NSTEP];
   logic [NSTEP-1:0] c_sat_quo [0:NSTEP];
   logic [CB-1:0]    c_hue_rem [0:NSTEP];
   logic [NSTEP-1:0] c_hue_num [0:NSTEP];
   logic [NSTEP-1:0] c_hue_quo [0:NSTEP];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   rgbhsv_front #(.CB(CB)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_pixel  (req_data),
      .out_valid (f_valid),
      .out_ctrl  (f_ctrl),
      .out_mx    (f_mx),
      .out_delta (f_delta),
      .out_mag   (f_mag)
   );

   // Dividends: delta times the full-scale channel value, and 60 times the
   // channel difference. Both quotients fit in NSTEP bits, so the top CB bits
   // of each dividend already lie below the divisor.
   always_comb begin
      sat_n = (NW'(f_delta) << CB) - NW'(f_delta);
      hue_n = NW'(f_mag) * NW'(HUE_SCALE);
   end

   assign c_valid[0]   = f_valid;
   assign c_ctrl[0]    = f_ctrl;
   assign c_mx[0]      = f_mx;
   assign c_delta[0]   = f_delta;
   assign c_sat_rem[0] = sat_n[NW-1:NSTEP];
   assign c_sat_num[0] = sat_n[NSTEP-1:0];
   assign c_sat_quo[0] = '0;
   assign c_hue_rem[0] = hue_n[NW-1:NSTEP];
   assign c_hue_num[0] = hue_n[NSTEP-1:0];
   assign c_hue_quo[0] = '0;

   for (genvar i = 0; i < NSTEP; i++) begin : g_cell
      rgbhsv_cell #(.CB(CB), .NSTEP(NSTEP)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (c_valid[i]),
         .in_ctrl     (c_ctrl[i]),
         .in_mx       (c_mx[i]),
         .in_delta    (c_delta[i]),
         .in_sat_rem  (c_sat_rem[i]),
         .in_sat_num  (c_sat_num[i]),
         .in_sat_quo  (c_sat_quo[i]),
         .in_hue_rem  (c_hue_rem[i]),
         .in_hue_num  (c_hue_num[i]),
         .in_hue_quo  (c_hue_quo[i]),
         .out_valid   (c_valid[i+1]),
         .out_ctrl    (c_ctrl[i+1]),
         .out_mx      (c_mx[i+1]),
         .out_delta   (c_delta[i+1]),
         .out_sat_rem (c_sat_rem[i+1]),
         .out_sat_num (c_sat_num[i+1]),
         .out_sat_quo (c_sat_quo[i+1]),
         .out_hue_rem (c_hue_rem[i+1]),
         .out_hue_num (c_hue_num[i+1]),
         .out_hue_quo (c_hue_quo[i+1])
      );
   end

   rgbhsv_back #(.CB(CB), .NSTEP(NSTEP)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (c_valid[NSTEP]),
      .in_ctrl    (c_ctrl[NSTEP]),
      .in_mx      (c_mx[NSTEP]),
      .in_sat_quo (c_sat_quo[NSTEP]),
      .in_hue_quo (c_hue_quo[NSTEP]),
      .in_hue_rem (c_hue_rem[NSTEP]),
      .out_strobe (rsp_strobe),
      .out_data   (rsp_data)
   );

endmodule
